// ----- src/rounded_integer_square_root_core_macros.svh -----
// Assertion macros used by the RTL of the rounded square root core.
`ifndef ROUNDED_INTEGER_SQUARE_ROOT_CORE_MACROS_SVH
`define ROUNDED_INTEGER_SQUARE_ROOT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RIRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rounded square root core: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RIRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rounded square root core: assertion failed");

`endif

// ----- src/rirs_pkg.sv -----
`default_nettype none

package rirs_pkg;

  // Field widths of the two channels.
  localparam int unsigned RadicandW = 31;
  localparam int unsigned RootW     = 16;

  // The radicand is padded to an even width so that each cell takes two bits.
  localparam int unsigned PadW = 2 * RootW;
  // The partial remainder never exceeds twice the partial root.
  localparam int unsigned RemW = RootW + 1;

  // One cell per root bit, then one register for the rounding decision.
  localparam int unsigned NumCells = RootW;
  localparam int unsigned Latency  = NumCells + 1;

  // Largest rounded root over the whole radicand range.
  localparam logic [RootW-1:0] RootMax = RootW'(46341);

  // Payload handed from one cell to the next.
  typedef struct packed {
    logic [PadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [RootW-1:0] q;
  } rirs_beat_t;

endpackage

`default_nettype wire

// ----- src/rirs_cell.sv -----
`default_nettype none

// One step of the restoring square root: brings down the next two radicand
// bits, tries the trial divisor and resolves one bit of the root.
module rirs_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire rirs_pkg::rirs_beat_t in_beat,
  output logic                   out_valid,
  output rirs_pkg::rirs_beat_t   out_beat
);

  logic [rirs_pkg::RemW+1:0] rem_sh;
  logic [rirs_pkg::RemW+1:0] trial;
  logic [rirs_pkg::RemW+1:0] diff;
  logic                      ge;
  rirs_pkg::rirs_beat_t      beat_next;

  // Shift in two radicand bits and compare against four times the root plus one.
  always_comb begin
    rem_sh = {in_beat.rem, in_beat.rad[rirs_pkg::PadW-1 -: 2]};
    trial  = {1'b0, in_beat.q, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    beat_next.rad = {in_beat.rad[rirs_pkg::PadW-3:0], 2'b00};
    beat_next.rem = ge ? diff[rirs_pkg::RemW-1:0] : rem_sh[rirs_pkg::RemW-1:0];
    beat_next.q   = {in_beat.q[rirs_pkg::RootW-2:0], ge};
  end

  // Valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= beat_next;
  end

endmodule

`default_nettype wire

// ----- src/rirs_round.sv -----
`default_nettype none

// Final stage: the remainder is the radicand less the square of the floor
// root, so the root rounds up exactly when the remainder exceeds it.
module rirs_round (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire rirs_pkg::rirs_beat_t       in_beat,
  output logic                            done,
  output logic [rirs_pkg::RootW-1:0]      root
);

  logic                      up;
  logic [rirs_pkg::RootW-1:0] root_next;

  // Compare remainder with the floor root and add the carry.
  always_comb begin
    up        = (in_beat.rem > {1'b0, in_beat.q});
    root_next = in_beat.q + {{(rirs_pkg::RootW-1){1'b0}}, up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    root <= root_next;
  end

endmodule

`default_nettype wire

// ----- src/rounded_integer_square_root_core.sv -----
// Channel   Handshake          Fields
// --------  -----------------  --------------------
// command   start / busy       radicand (31 bits)
// result    done (one cycle)   root (16 bits)
//
// A radicand is taken on any edge with start high and busy low, one per cycle.
// Each beat passes 16 root cells, one per root bit, and a rounding register,
// from which its root appears with done.
// busy is high only while rst is held; reset empties the cell chain.
// The receiver cannot stall: every root is shown for one cycle only.
`default_nettype none

`include "rounded_integer_square_root_core_macros.svh"

module rounded_integer_square_root_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [rirs_pkg::RadicandW-1:0]   radicand,
  output logic                                  done,
  output logic [rirs_pkg::RootW-1:0]            root
);

  logic                 valid [rirs_pkg::NumCells+1];
  rirs_pkg::rirs_beat_t beat  [rirs_pkg::NumCells+1];
  logic                 accept;

  // The chain accepts a beat in every cycle outside reset.
  assign busy   = rst;
  assign accept = start & ~busy;

  // Head of the chain: zero remainder and root, radicand padded to even width.
  always_comb begin
    valid[0]     = accept;
    beat[0].rad  = {{(rirs_pkg::PadW-rirs_pkg::RadicandW){1'b0}}, radicand};
    beat[0].rem  = '0;
    beat[0].q    = '0;
  end

  // Row of identical cells, each resolving one root bit.
  for (genvar i = 0; i < rirs_pkg::NumCells; i++) begin : g_cell
    rirs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_beat   (beat[i]),
      .out_valid (valid[i+1]),
      .out_beat  (beat[i+1])
    );
  end

  // Rounding decision and output register.
  rirs_round u_round (
    .clk      (clk),
    .rst      (rst),
    .in_valid (valid[rirs_pkg::NumCells]),
    .in_beat  (beat[rirs_pkg::NumCells]),
    .done     (done),
    .root     (root)
  );

  // Every result beat stems from a command beat taken earlier.
  `RIRS_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(accept, rirs_pkg::Latency))
  // The rounded root never exceeds the root of the largest radicand.
  `RIRS_ASSERT_IMPL(a_root_range, clk, rst, done, root <= rirs_pkg::RootMax)
  // A zero radicand yields a zero root.
  `RIRS_ASSERT_IMPL(a_zero_root, clk, rst,
                    done && ($past(radicand, rirs_pkg::Latency) == '0), root == '0)

endmodule

`default_nettype wire

// ----- tb/sv/rirs_root_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the rounded square root core, predicts the root of
// every radicand beat taken and compares it with the root beat that comes out.
module rirs_root_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [rirs_pkg::RadicandW-1:0] radicand,
  input  wire logic                           done,
  input  wire logic [rirs_pkg::RootW-1:0]     root,
  output int unsigned                         roots_pending,
  output int unsigned                         fail_count
);

  typedef struct packed {
    logic [rirs_pkg::RadicandW-1:0] radicand;
    logic [rirs_pkg::RootW-1:0]     root;
  } root_expectation_t;

  root_expectation_t expected_roots[$];

  // Restoring binary square root over a 32-bit padded radicand. The final
  // remainder is radicand minus the floor root squared, so the root is
  // rounded up exactly when that remainder exceeds the floor root.
  function automatic logic [rirs_pkg::RootW-1:0] rounded_root_of(
    logic [rirs_pkg::RadicandW-1:0] value
  );
    logic [31:0] remainder;
    logic [31:0] partial;
    logic [31:0] weight;
    remainder = {1'b0, value};
    partial   = '0;
    weight    = 32'h4000_0000;
    for (int i = 0; i < 16; i++) begin
      if (remainder >= partial + weight) begin
        remainder = remainder - (partial + weight);
        partial   = (partial >> 1) + weight;
      end else begin
        partial = partial >> 1;
      end
      weight = weight >> 2;
    end
    if (remainder > partial) begin
      return partial[rirs_pkg::RootW-1:0] + 1'b1;
    end
    return partial[rirs_pkg::RootW-1:0];
  endfunction

  initial begin
    roots_pending = 0;
    fail_count    = 0;
  end

  // A radicand beat is taken when start is high and busy low; a root beat is
  // taken whenever done is high, since the receiver cannot hold it off.
  always @(posedge clk) begin
    root_expectation_t oldest;
    if (!rst) begin
      if (start && !busy) begin
        expected_roots.push_back('{radicand: radicand, root: rounded_root_of(radicand)});
      end
      if (done) begin
        if (expected_roots.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: root beat with none expected: expected none, actual %0d",
                   $time, root);
        end else begin
          oldest = expected_roots.pop_front();
          if (root !== oldest.root) begin
            fail_count = fail_count + 1;
            $display("%0t: root of radicand %0d: expected %0d, actual %0d",
                     $time, oldest.radicand, oldest.root, root);
          end
        end
      end
      roots_pending = expected_roots.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Drives radicand beats into the rounded square root core in random bursts
// and gives the verdict from the failure count of the checker.
module tb_top;

  localparam int unsigned RandomBeats = 400;
  localparam logic [rirs_pkg::RadicandW-1:0] RadicandMax = {rirs_pkg::RadicandW{1'b1}};

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [rirs_pkg::RadicandW-1:0] radicand;
  logic                           done;
  logic [rirs_pkg::RootW-1:0]     root;
  int unsigned                    roots_pending;
  int unsigned                    fail_count;
  int unsigned                    burst_left;

  rounded_integer_square_root_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .radicand (radicand),
    .done     (done),
    .root     (root)
  );

  rirs_root_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .radicand      (radicand),
    .done          (done),
    .root          (root),
    .roots_pending (roots_pending),
    .fail_count    (fail_count)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one radicand beat from a falling edge and returns at the falling
  // edge after it was taken, with start still high.
  task automatic offer_radicand(input logic [rirs_pkg::RadicandW-1:0] value);
    start    <= 1'b1;
    radicand <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Keeps the sender in bursts: once a burst is used up, start drops for a
  // random gap (sometimes none) before the next burst begins.
  task automatic send_in_burst(input logic [rirs_pkg::RadicandW-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left = burst_left - 1;
    offer_radicand(value);
  endtask

  // Random radicand drawn from a mix of shapes: the full range, values about
  // a perfect square, random bit lengths and small values.
  function automatic logic [rirs_pkg::RadicandW-1:0] random_radicand();
    logic [31:0] base;
    logic [31:0] square;
    logic [31:0] value;
    int unsigned bits;
    value = '0;
    case ($urandom_range(3))
      0: value = $urandom();
      1: begin
        base   = $urandom_range(46340);
        square = base * base;
        case ($urandom_range(4))
          0: value = square;
          1: value = (base == 0) ? square : square - 1;
          2: value = square + base;
          3: value = square + base + 1;
          default: value = square + $urandom_range(2 * base);
        endcase
      end
      2: begin
        bits  = $urandom_range(1, rirs_pkg::RadicandW);
        value = $urandom() >> (32 - bits);
      end
      default: value = $urandom_range(1000);
    endcase
    return value[rirs_pkg::RadicandW-1:0];
  endfunction

  initial begin
    logic [rirs_pkg::RadicandW-1:0] directed[$];
    rst        = 1'b1;
    start      = 1'b0;
    radicand   = '0;
    burst_left = 0;

    // Zero, the smallest values and the first rounding boundaries.
    directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7, 31'd8, 31'd9};
    // Largest radicand, whose root is the largest that can come out.
    directed.push_back(RadicandMax);
    directed.push_back(RadicandMax - 1'b1);
    // About the largest square: 46340 squared, the value below it, the last value
    // still rounding down to it and the first rounding up to the largest root.
    directed.push_back(31'd2147395600);
    directed.push_back(31'd2147395599);
    directed.push_back(31'd2147441940);
    directed.push_back(31'd2147441941);
    // Alternating bit patterns, a single high bit and the value just below it.
    directed.push_back(31'h5555_5555);
    directed.push_back(31'h2AAA_AAAA);
    directed.push_back(31'h4000_0000);
    directed.push_back(31'h3FFF_FFFF);
    // A midpoint neighbourhood: 1000 squared plus 1000 rounds down, plus 1001 up.
    directed.push_back(31'd1001000);
    directed.push_back(31'd1001001);

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_in_burst(directed[i]);
    end
    for (int i = 0; i < RandomBeats; i++) begin
      send_in_burst(random_radicand());
    end
    start <= 1'b0;

    // Drain every root still in the cell chain, then let it settle.
    while (roots_pending != 0) @(negedge clk);
    repeat (rirs_pkg::Latency + 4) @(negedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
